// File: rtl/nbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbb_pkg: shared types for the non-black bounding box block
// register indexes, field widths and the result record
// ----------------------------------------------------------------------------
package nbb_pkg;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 13;
	localparam int CHAN_W    = 8;
	localparam int COORD_W   = 12;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_W-1:0]     cfg_val_t;
	typedef logic [CHAN_W-1:0]    chan_t;
	typedef logic [COORD_W-1:0]   coord_t;

	localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);

	localparam cfg_val_t WIDTH_RESET  = cfg_val_t'(640);
	localparam cfg_val_t HEIGHT_RESET = cfg_val_t'(480);

	typedef struct packed {
		logic   found_any;
		coord_t top_row;
		coord_t top_col;
		coord_t bottom_row;
		coord_t bottom_col;
		coord_t left_col;
		coord_t left_row;
		coord_t right_col;
		coord_t right_row;
	} result_t;

endpackage

// File: rtl/nonblack_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonblack_bounding_box: extreme non-black pixels of a raster-order frame
// tracks top, bottom, left and right non-black pixels and emits one result
// transaction after the last pixel of each frame
// ----------------------------------------------------------------------------
// result path: last pixel of a frame -> input register -> result register
// throughput: 1 pixel per cycle, set by the tracking update stage that follows
// the input register; a frame's last pixel waits while a result is pending
// reset: width 640, height 480, position and tracking cleared, no result
// pending; no clearing pass, pixels are taken right after reset
// ----------------------------------------------------------------------------
module nonblack_bounding_box #(
	parameter int MAX_DIM = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  nbb_pkg::cfg_idx_t       cfg_index,
	input  nbb_pkg::cfg_val_t       cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  nbb_pkg::chan_t          chan_a,
	input  nbb_pkg::chan_t          chan_b,
	input  nbb_pkg::chan_t          chan_c,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found_any,
	output nbb_pkg::coord_t         top_row,
	output nbb_pkg::coord_t         top_col,
	output nbb_pkg::coord_t         bottom_row,
	output nbb_pkg::coord_t         bottom_col,
	output nbb_pkg::coord_t         left_col,
	output nbb_pkg::coord_t         left_row,
	output nbb_pkg::coord_t         right_col,
	output nbb_pkg::coord_t         right_row
);

	localparam int POS_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int EXT_W = ((DIM_W > nbb_pkg::CFG_W) ? DIM_W : nbb_pkg::CFG_W) + 1;
	localparam logic [EXT_W-1:0] MAX_EXT = EXT_W'(MAX_DIM);
	localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1);

	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		logic seen;
		pos_t top_row;
		pos_t top_col;
		pos_t bottom_row;
		pos_t bottom_col;
		pos_t left_col;
		pos_t left_row;
		pos_t right_col;
		pos_t right_row;
	} track_t;

	nbb_pkg::cfg_val_t width_q, height_q;
	logic              valid_s1, lit_s1;
	pos_t              row_q, col_q;
	track_t            trk_q, trk_next;
	logic              out_valid_q;
	nbb_pkg::result_t  res_q;

	logic [EXT_W-1:0] w_raw, h_raw, w_eff, h_eff;
	logic [EXT_W-1:0] col_inc, row_inc;
	logic             row_end, frame_end, advance;

	assign cfg_ready = 1'b1;

	// dimension clamp
	assign w_raw = EXT_W'(width_q);
	assign h_raw = EXT_W'(height_q);
	assign w_eff = (w_raw == '0) ? ONE_EXT : ((w_raw > MAX_EXT) ? MAX_EXT : w_raw);
	assign h_eff = (h_raw == '0) ? ONE_EXT : ((h_raw > MAX_EXT) ? MAX_EXT : h_raw);

	assign col_inc   = EXT_W'(col_q) + ONE_EXT;
	assign row_inc   = EXT_W'(row_q) + ONE_EXT;
	assign row_end   = col_inc >= w_eff;
	assign frame_end = row_end && (row_inc >= h_eff);

	assign advance  = valid_s1 && (!frame_end || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		trk_next = trk_q;
		if (lit_s1) begin
			if (!trk_q.seen) begin
				trk_next.seen       = 1'b1;
				trk_next.top_row    = row_q;
				trk_next.top_col    = col_q;
				trk_next.bottom_row = row_q;
				trk_next.bottom_col = col_q;
				trk_next.left_col   = col_q;
				trk_next.left_row   = row_q;
				trk_next.right_col  = col_q;
				trk_next.right_row  = row_q;
			end else begin
				if (row_q == trk_q.top_row) begin
					trk_next.top_col = col_q;
				end
				trk_next.bottom_row = row_q;
				trk_next.bottom_col = col_q;
				if (col_q <= trk_q.left_col) begin
					trk_next.left_col = col_q;
					trk_next.left_row = row_q;
				end
				if (col_q >= trk_q.right_col) begin
					trk_next.right_col = col_q;
					trk_next.right_row = row_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nbb_pkg::WIDTH_RESET;
			height_q <= nbb_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nbb_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
				nbb_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			lit_s1 <= (chan_a | chan_b | chan_c) != '0;
		end
	end

	// position and tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			trk_q <= '0;
		end else if (advance) begin
			if (frame_end) begin
				row_q <= '0;
				col_q <= '0;
				trk_q <= '0;
			end else begin
				trk_q <= trk_next;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + pos_t'(1);
				end else begin
					col_q <= col_q + pos_t'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end) begin
			res_q.found_any  <= trk_next.seen;
			res_q.top_row    <= nbb_pkg::coord_t'(trk_next.top_row);
			res_q.top_col    <= nbb_pkg::coord_t'(trk_next.top_col);
			res_q.bottom_row <= nbb_pkg::coord_t'(trk_next.bottom_row);
			res_q.bottom_col <= nbb_pkg::coord_t'(trk_next.bottom_col);
			res_q.left_col   <= nbb_pkg::coord_t'(trk_next.left_col);
			res_q.left_row   <= nbb_pkg::coord_t'(trk_next.left_row);
			res_q.right_col  <= nbb_pkg::coord_t'(trk_next.right_col);
			res_q.right_row  <= nbb_pkg::coord_t'(trk_next.right_row);
		end
	end

	assign out_valid  = out_valid_q;
	assign found_any  = res_q.found_any;
	assign top_row    = res_q.top_row;
	assign top_col    = res_q.top_col;
	assign bottom_row = res_q.bottom_row;
	assign bottom_col = res_q.bottom_col;
	assign left_col   = res_q.left_col;
	assign left_row   = res_q.left_row;
	assign right_col  = res_q.right_col;
	assign right_row  = res_q.right_row;

endmodule

// File: test/nonblack_bounding_box_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonblack_bounding_box_tb: self-checking bench for the non-black bounding box
// streams whole raster frames through the block under random flow control,
// predicts each frame's extreme non-black pixels and compares every result
// transaction field by field; frame sizes are rewritten between phases,
// including zero sizes that clamp to one
// ----------------------------------------------------------------------------
module nonblack_bounding_box_tb;

	localparam int MAX_DIM     = 4096;
	localparam int LATENCY     = 2;
	localparam int QUIET_LIMIT = 2000;
	localparam int PIXEL_GOAL  = 1200;
	localparam int FRAME_GOAL  = 48;

	localparam nbb_pkg::cfg_idx_t REG_SPARE_LO = nbb_pkg::cfg_idx_t'(2);
	localparam nbb_pkg::cfg_idx_t REG_SPARE_HI = nbb_pkg::cfg_idx_t'(15);

	class bbox_tracker;
		int unsigned      width_reg;
		int unsigned      height_reg;
		int unsigned      row;
		int unsigned      col;
		nbb_pkg::result_t box;
		nbb_pkg::result_t pending_boxes[$];
		int unsigned      errors;
		int unsigned      boxes_checked;
		int unsigned      pixels;

		function new();
			width_reg     = 32'(nbb_pkg::WIDTH_RESET);
			height_reg    = 32'(nbb_pkg::HEIGHT_RESET);
			errors        = 0;
			boxes_checked = 0;
			pixels        = 0;
			clear_frame();
		endfunction

		static function int unsigned eff_dim(int unsigned raw);
			if (raw < 1) return 1;
			if (raw > MAX_DIM) return MAX_DIM;
			return raw;
		endfunction

		function void clear_frame();
			row = 0;
			col = 0;
			box = '0;
		endfunction

		function void write_reg(nbb_pkg::cfg_idx_t idx, nbb_pkg::cfg_val_t val);
			if (idx == nbb_pkg::REG_FRAME_WIDTH) width_reg = 32'(val);
			else if (idx == nbb_pkg::REG_FRAME_HEIGHT) height_reg = 32'(val);
		endfunction

		function void take_pixel(nbb_pkg::chan_t a, nbb_pkg::chan_t b, nbb_pkg::chan_t c);
			nbb_pkg::coord_t r;
			nbb_pkg::coord_t k;
			r = nbb_pkg::coord_t'(row);
			k = nbb_pkg::coord_t'(col);
			pixels++;
			if ((a | b | c) != '0) begin
				if (!box.found_any) begin
					box = '{1'b1, r, k, r, k, k, r, k, r};
				end else begin
					if (r == box.top_row) box.top_col = k;
					box.bottom_row = r;
					box.bottom_col = k;
					if (k <= box.left_col) begin
						box.left_col = k;
						box.left_row = r;
					end
					if (k >= box.right_col) begin
						box.right_col = k;
						box.right_row = r;
					end
				end
			end
			if (col + 1 < eff_dim(width_reg)) begin
				col++;
			end else if (row + 1 < eff_dim(height_reg)) begin
				col = 0;
				row++;
			end else begin
				pending_boxes.push_back(box);
				clear_frame();
			end
		endfunction

		function void cmp(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				if (errors < 10)
					$display("box %0d %s: expected %0d, got %0d",
						boxes_checked, field, want, got);
				errors++;
			end
		endfunction

		function void check_box(nbb_pkg::result_t got);
			nbb_pkg::result_t want;
			if (pending_boxes.size() == 0) begin
				if (errors < 10)
					$display("result transaction with no frame pending: %h", got);
				errors++;
				return;
			end
			want = pending_boxes.pop_front();
			boxes_checked++;
			cmp("found_any", 32'(want.found_any), 32'(got.found_any));
			cmp("top_row", 32'(want.top_row), 32'(got.top_row));
			cmp("top_col", 32'(want.top_col), 32'(got.top_col));
			cmp("bottom_row", 32'(want.bottom_row), 32'(got.bottom_row));
			cmp("bottom_col", 32'(want.bottom_col), 32'(got.bottom_col));
			cmp("left_col", 32'(want.left_col), 32'(got.left_col));
			cmp("left_row", 32'(want.left_row), 32'(got.left_row));
			cmp("right_col", 32'(want.right_col), 32'(got.right_col));
			cmp("right_row", 32'(want.right_row), 32'(got.right_row));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	nbb_pkg::cfg_idx_t cfg_index;
	nbb_pkg::cfg_val_t cfg_data;
	logic              in_valid;
	logic              in_ready;
	nbb_pkg::chan_t    chan_a;
	nbb_pkg::chan_t    chan_b;
	nbb_pkg::chan_t    chan_c;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              found_any;
	nbb_pkg::coord_t   top_row;
	nbb_pkg::coord_t   top_col;
	nbb_pkg::coord_t   bottom_row;
	nbb_pkg::coord_t   bottom_col;
	nbb_pkg::coord_t   left_col;
	nbb_pkg::coord_t   left_row;
	nbb_pkg::coord_t   right_col;
	nbb_pkg::coord_t   right_row;

	bbox_tracker      tracker;
	nbb_pkg::result_t seen_box;
	bit               steady_in = 1'b0;
	int               ready_left = 0;
	int               quiet_cycles = 0;
	int unsigned      frames_sent = 0;
	int unsigned      cfg_writes = 0;

	nonblack_bounding_box #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.chan_a    (chan_a),
		.chan_b    (chan_b),
		.chan_c    (chan_c),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found_any (found_any),
		.top_row   (top_row),
		.top_col   (top_col),
		.bottom_row(bottom_row),
		.bottom_col(bottom_col),
		.left_col  (left_col),
		.left_row  (left_row),
		.right_col (right_col),
		.right_row (right_row)
	);

	always #2 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [23:0] lit_value();
		logic [23:0] v;
		case ($urandom_range(0, 3))
			0: v = 24'($urandom_range(1, 255)) << (8 * $urandom_range(0, 2));
			1: v = 24'hFFFFFF;
			default: v = 24'($urandom);
		endcase
		if (v == '0) v = 24'h000001;
		return v;
	endfunction

	function automatic nbb_pkg::cfg_val_t pick_dim(int unsigned hi_small, int unsigned hi_mid);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75) return nbb_pkg::cfg_val_t'($urandom_range(1, hi_small));
		if (r < 90) return nbb_pkg::cfg_val_t'($urandom_range(hi_small + 1, hi_mid));
		return (r < 95) ? nbb_pkg::cfg_val_t'(0) : nbb_pkg::cfg_val_t'(1);
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if (out_ready && $urandom_range(0, 1) == 0) begin
			out_ready  <= 1'b0;
			ready_left <= idle_len();
		end else begin
			out_ready  <= 1'b1;
			ready_left <= $urandom_range(0, 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen_box = '{found_any, top_row, top_col, bottom_row, bottom_col,
					left_col, left_row, right_col, right_row};
				tracker.check_box(seen_box);
			end
			if (in_valid && in_ready) tracker.take_pixel(chan_a, chan_b, chan_c);
			if (cfg_valid && cfg_ready) begin
				tracker.write_reg(cfg_index, cfg_data);
				cfg_writes++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d cycles with no transaction", quiet_cycles);
			$display("nonblack_bounding_box regression: fail");
			$finish;
		end
	end

	task automatic send_pixel(input nbb_pkg::chan_t a, input nbb_pkg::chan_t b,
		input nbb_pkg::chan_t c);
		int gap;
		gap = steady_in ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		chan_a   <= a;
		chan_b   <= b;
		chan_c   <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_cfg(input nbb_pkg::cfg_idx_t idx, input nbb_pkg::cfg_val_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every frame result is back and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_boxes.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_dims(input nbb_pkg::cfg_val_t w, input nbb_pkg::cfg_val_t h);
		settle();
		send_cfg(nbb_pkg::REG_FRAME_WIDTH, w);
		send_cfg(nbb_pkg::REG_FRAME_HEIGHT, h);
	endtask

	task automatic send_random_frame(input int unsigned w, input int unsigned h,
		input int unsigned density, input bit last_lit);
		int unsigned n;
		logic [23:0] v;
		steady_in = ($urandom_range(0, 4) == 0);
		for (n = 0; n < w * h; n++) begin
			if ($urandom_range(0, 99) < density || (last_lit && n == w * h - 1))
				v = lit_value();
			else
				v = '0;
			send_pixel(v[23:16], v[15:8], v[7:0]);
		end
		frames_sent++;
	endtask

	task automatic run_extreme(input nbb_pkg::cfg_val_t w, input nbb_pkg::cfg_val_t h);
		set_dims(w, h);
		send_random_frame(bbox_tracker::eff_dim(32'(w)), bbox_tracker::eff_dim(32'(h)),
			1, 1'b1);
	endtask

	initial begin
		nbb_pkg::cfg_val_t w;
		nbb_pkg::cfg_val_t h;
		int unsigned       density;
		int unsigned       r;
		tracker   = new();
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		chan_a    <= '0;
		chan_b    <= '0;
		chan_c    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero dimensions act as a single pixel frame
		set_dims(nbb_pkg::cfg_val_t'(0), nbb_pkg::cfg_val_t'(0));
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h00);
		frames_sent += 2;

		// ties on the left and right columns across rows
		set_dims(nbb_pkg::cfg_val_t'(3), nbb_pkg::cfg_val_t'(3));
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h01, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h80);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h01, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h00);
		frames_sent++;

		// first non-black row is not row zero
		set_dims(nbb_pkg::cfg_val_t'(4), nbb_pkg::cfg_val_t'(2));
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h55, 8'hAA, 8'h0F);
		send_pixel(8'h80, 8'h00, 8'h01);
		send_pixel(8'h00, 8'h00, 8'h00);
		frames_sent++;

		while (tracker.pixels < PIXEL_GOAL || frames_sent < FRAME_GOAL) begin
			w = pick_dim(6, 24);
			h = pick_dim(5, 16);
			set_dims(w, h);
			repeat ($urandom_range(1, 4)) begin
				r = $urandom_range(0, 99);
				if (r < 20) density = 0;
				else if (r < 35) density = 100;
				else density = $urandom_range(5, 60);
				send_random_frame(bbox_tracker::eff_dim(32'(w)),
					bbox_tracker::eff_dim(32'(h)), density, 1'b0);
			end
		end

		// unused register indexes must be ignored
		settle();
		send_cfg(REG_SPARE_LO, nbb_pkg::cfg_val_t'($urandom));
		send_cfg(REG_SPARE_HI, '1);

		run_extreme(nbb_pkg::cfg_val_t'(0), nbb_pkg::cfg_val_t'(7));
		run_extreme(nbb_pkg::cfg_val_t'(9), nbb_pkg::cfg_val_t'(0));
		run_extreme(nbb_pkg::cfg_val_t'(1), nbb_pkg::cfg_val_t'(1));

		settle();
		repeat (4 * LATENCY + 4) @(posedge clk);

		$display("streamed %0d pixels in %0d frames with %0d register writes",
			tracker.pixels, frames_sent, cfg_writes);
		$display("compared %0d result transactions, %0d mismatches",
			tracker.boxes_checked, tracker.errors);
		if (tracker.errors == 0 && tracker.pending_boxes.size() == 0)
			$display("nonblack_bounding_box regression: pass");
		else
			$display("nonblack_bounding_box regression: fail");
		$finish;
	end

endmodule
